// ===== rtl/wrc_pkg.sv =====
// Shared types and constants for the wildcard rule classifier.
// Holds transfer payload structs and the pipeline stage records.
// No dependencies.
`default_nettype none

package wrc_pkg;

  localparam int MAX_RULES   = 64;
  localparam int SLOT_BITS   = 6;
  localparam int KEY_BITS    = 32;
  localparam int ACTION_BITS = 8;
  localparam int COUNT_BITS  = 7;

  // priority encoder split: GROUPS groups of GROUP_SIZE rules
  localparam int GIDX_BITS   = 3;
  localparam int GROUP_BITS  = SLOT_BITS - GIDX_BITS;
  localparam int GROUP_SIZE  = 1 << GIDX_BITS;
  localparam int GROUPS      = MAX_RULES / GROUP_SIZE;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic                   kind;
    logic [SLOT_BITS-1:0]   rule_slot;
    logic [KEY_BITS-1:0]    source_key;
    logic [KEY_BITS-1:0]    dest_key;
    logic                   source_any;
    logic                   dest_any;
    logic [ACTION_BITS-1:0] action_in;
  } in_item_t;

  typedef struct packed {
    logic                   matched;
    logic [SLOT_BITS-1:0]   hit_slot;
    logic [ACTION_BITS-1:0] action_out;
  } out_item_t;

  // after compare: one hit bit per rule
  typedef struct packed {
    logic                   kind;
    logic [SLOT_BITS-1:0]   slot;
    logic [ACTION_BITS-1:0] action;
    logic [MAX_RULES-1:0]   hits;
  } s1_t;

  // after first encoder level: per-group hit flag and first index
  typedef struct packed {
    logic                                 kind;
    logic [SLOT_BITS-1:0]                 slot;
    logic [ACTION_BITS-1:0]               action;
    logic [GROUPS-1:0]                    grp_any;
    logic [GROUPS-1:0][GIDX_BITS-1:0]     grp_idx;
  } s2_t;

  // slot resolved: load slot or winning rule
  typedef struct packed {
    logic                   kind;
    logic                   matched;
    logic [SLOT_BITS-1:0]   slot;
    logic [ACTION_BITS-1:0] action;
  } s3_t;

endpackage

`default_nettype wire

// ===== rtl/wildcard_rule_classifier.sv =====
// First-match classifier over 64 wildcard rules, four register stages.
// Stages in order: compare, group encode, group select, action memory read;
// throughput one item per cycle while out_ready does not hold the output.
// Loads flow through the pipeline too and give no result.
// Reset clears valid bits and rule_count; the rule table is not cleared.
`default_nettype none

module wildcard_rule_classifier
  import wrc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [COUNT_BITS-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data
);

  logic s1_valid;
  logic s1_ready;
  s1_t  s1;
  logic s3_valid;
  logic s3_ready;
  s3_t  s3;

  wrc_match u_match (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1        (s1)
  );

  wrc_prio u_prio (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1),
    .s3_valid (s3_valid),
    .s3_ready (s3_ready),
    .s3       (s3)
  );

  wrc_action u_action (
    .clk       (clk),
    .rst       (rst),
    .s3_valid  (s3_valid),
    .s3_ready  (s3_ready),
    .s3        (s3),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // input only backs up when every stage is full and the output is held
  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.matched) |->
      (out_data.hit_slot == '0 && out_data.action_out == '0))
    else $error("drop result carries non-zero slot or action");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_ready && s3.kind == KIND_LOAD) |=> !out_valid)
    else $error("load produced a result");

  a_lookup_result: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_ready && s3.kind == KIND_LOOKUP) |=> out_valid)
    else $error("lookup lost at output stage");
`endif

endmodule

`default_nettype wire

// ===== rtl/wrc_match.sv =====
// Rule key table, rule count register and parallel compare stage.
// Depends on wrc_pkg.
`default_nettype none

module wrc_match
  import wrc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [COUNT_BITS-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       s1_valid,
  input  wire logic                  s1_ready,
  output s1_t                        s1
);

  logic [KEY_BITS-1:0] src_keys [MAX_RULES];
  logic [KEY_BITS-1:0] dst_keys [MAX_RULES];
  logic [MAX_RULES-1:0] src_wild;
  logic [MAX_RULES-1:0] dst_wild;
  logic [COUNT_BITS-1:0] rule_count;
  logic [MAX_RULES-1:0] hits_next;
  logic accept;

  assign in_ready = !s1_valid || s1_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count <= '0;
    end else if (cfg_we) begin
      rule_count <= cfg_wdata;
    end
  end

  // table written at transfer; a following lookup sees it next cycle
  always_ff @(posedge clk) begin
    if (accept && in_data.kind == KIND_LOAD) begin
      src_keys[in_data.rule_slot] <= in_data.source_key;
      dst_keys[in_data.rule_slot] <= in_data.dest_key;
      src_wild[in_data.rule_slot] <= in_data.source_any;
      dst_wild[in_data.rule_slot] <= in_data.dest_any;
    end
  end

  // counts above the table size enable every rule
  always_comb begin
    for (int i = 0; i < MAX_RULES; i++) begin
      hits_next[i] = (COUNT_BITS'(i) < rule_count)
                   && (src_wild[i] || src_keys[i] == in_data.source_key)
                   && (dst_wild[i] || dst_keys[i] == in_data.dest_key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.kind   <= in_data.kind;
      s1.slot   <= in_data.rule_slot;
      s1.action <= in_data.action_in;
      s1.hits   <= hits_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wrc_prio.sv =====
// Two-stage priority encoder: first hit per group, then first group.
// Depends on wrc_pkg.
`default_nettype none

module wrc_prio
  import wrc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s1_valid,
  output logic      s1_ready,
  input  wire s1_t  s1,
  output logic      s3_valid,
  input  wire logic s3_ready,
  output s3_t       s3
);

  logic s2_valid;
  logic s2_ready;
  s2_t  s2;
  s2_t  s2_next;
  s3_t  s3_next;

  assign s1_ready = !s2_valid || s2_ready;
  assign s2_ready = !s3_valid || s3_ready;

  always_comb begin
    s2_next.kind   = s1.kind;
    s2_next.slot   = s1.slot;
    s2_next.action = s1.action;
    for (int g = 0; g < GROUPS; g++) begin
      s2_next.grp_any[g] = |s1.hits[g*GROUP_SIZE +: GROUP_SIZE];
      s2_next.grp_idx[g] = '0;
      for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
        if (s1.hits[g*GROUP_SIZE + j]) begin
          s2_next.grp_idx[g] = GIDX_BITS'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      s2 <= s2_next;
    end
  end

  always_comb begin
    s3_next.kind    = s2.kind;
    s3_next.action  = s2.action;
    s3_next.matched = 1'b0;
    s3_next.slot    = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (s2.grp_any[g]) begin
        s3_next.matched = 1'b1;
        s3_next.slot    = {GROUP_BITS'(g), s2.grp_idx[g]};
      end
    end
    if (s2.kind == KIND_LOAD) begin
      s3_next.matched = 1'b0;
      s3_next.slot    = s2.slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s2_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_ready) begin
      s3 <= s3_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wrc_action.sv =====
// Action memory and output register stage.
// Loads write the memory here, in order with lookups. Depends on wrc_pkg.
`default_nettype none

module wrc_action
  import wrc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s3_valid,
  output logic      s3_ready,
  input  wire s3_t  s3,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  logic [ACTION_BITS-1:0] act_mem [MAX_RULES];
  logic [ACTION_BITS-1:0] act_rd;
  logic                   o_matched;
  logic [SLOT_BITS-1:0]   o_slot;
  logic                   adv;

  assign s3_ready = !out_valid || out_ready;
  assign adv      = s3_valid && s3_ready;

  always_ff @(posedge clk) begin
    if (adv && s3.kind == KIND_LOAD) begin
      act_mem[s3.slot] <= s3.action;
    end
    if (adv && s3.kind == KIND_LOOKUP) begin
      act_rd <= act_mem[s3.slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_ready) begin
      out_valid <= s3_valid && s3.kind == KIND_LOOKUP;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3.kind == KIND_LOOKUP) begin
      o_matched <= s3.matched;
      o_slot    <= s3.slot;
    end
  end

  // drop reports zero slot and action
  assign out_data.matched    = o_matched;
  assign out_data.hit_slot   = o_matched ? o_slot : '0;
  assign out_data.action_out = o_matched ? act_rd : '0;

endmodule

`default_nettype wire
